// ----- hdl/pate_pkg.sv -----
// shared types and constants for the packed array table engine
package pate_pkg;

  localparam int MODE_W     = 2;
  localparam int INDEX_W    = 8;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int POSITION_W = 8;
  localparam int FILL_W     = 9;
  localparam int MAX_IW     = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_SEARCH = 2'd0,
    MODE_MODIFY = 2'd1,
    MODE_APPEND = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_ROTATE = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_APPEND = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [MAX_IW-1:0]   sel;
  } cell_cmd_t;

endpackage

// ----- hdl/pate_ifs.sv -----
// valid/ready channel interfaces for request and result beats
interface pate_in_if;
  import pate_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [INDEX_W-1:0]        index;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, mode, index, value, input ready);
  modport sink (input valid, mode, index, value, output ready);
endinterface

interface pate_out_if;
  import pate_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [POSITION_W-1:0]     position;
  logic signed [VALUE_W-1:0] old_value;
  logic [FILL_W-1:0]         fill_count;

  modport source (output valid, status, position, old_value, fill_count, input ready);
  modport sink (input valid, status, position, old_value, fill_count, output ready);
endinterface

// ----- hdl/packed_array_table_engine.sv -----
// packed table engine top: controller, result register and the rotating cell chain
// append, remove and out-of-range modify load their result beat at accept, valid in the next cycle
// search and in-range modify walk the chain in S_WALK, then load their result in S_POST once out_free
// one request at a time: search and in-range modify rotate the whole chain once,
//   one position per cycle, before their result beat is loaded
// reset: clears fill count and handshake state; entries are not cleared and need no sweep
module packed_array_table_engine #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  pate_in_if.sink    in_ch,
  pate_out_if.source out_ch
);
  import pate_pkg::*;

  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [IW-1:0] LAST_STEP = IW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_POST} state_t;

  state_t               state_r;
  mode_t                op_r;
  logic [INDEX_W-1:0]   idx_r;
  logic [VALUE_W-1:0]   key_r;
  logic [IW-1:0]        step_r;
  logic                 found_r;
  logic [POSITION_W-1:0] pos_r;
  logic [VALUE_W-1:0]   old_r;
  logic [CW-1:0]        count_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [POSITION_W-1:0] out_position_r;
  logic [VALUE_W-1:0]    out_old_r;
  logic [FILL_W-1:0]     out_fill_r;

  logic                 in_ready;
  logic                 accept;
  mode_t                in_mode;
  logic                 in_range;
  logic                 full;
  logic                 hit_idx;
  logic                 out_free;
  logic                 out_load;
  logic [CW-1:0]        count_inc;
  logic [CW-1:0]        count_dec;
  cell_cmd_t            cmd;
  logic [VALUE_W-1:0]   tail;
  logic [VALUE_W-1:0]   cell_q [TABLE_DEPTH];

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_ch.valid && in_ready;
  assign in_mode   = mode_t'(in_ch.mode);
  assign in_range  = CMPW'(in_ch.index) < CMPW'(count_r);
  assign full      = (count_r == DEPTH_CNT);
  assign hit_idx   = CMPW'(step_r) == CMPW'(idx_r);
  assign count_inc = count_r + CW'(1);
  assign count_dec = count_r - CW'(1);

  // result register loads a new beat this cycle
  assign out_load  = (accept && (in_mode != MODE_SEARCH)
                      && !(in_mode == MODE_MODIFY && in_range))
                     || (state_r == S_POST && out_free);

  always_comb begin
    cmd.op  = CELL_HOLD;
    cmd.sel = '0;
    tail    = cell_q[0];
    if (state_r == S_WALK) begin
      cmd.op = CELL_ROTATE;
      if (op_r == MODE_MODIFY && hit_idx) tail = key_r;
    end else if (accept) begin
      case (in_mode)
        MODE_APPEND: begin
          if (!full) begin
            cmd.op  = CELL_APPEND;
            cmd.sel = MAX_IW'(count_r);
          end
        end
        MODE_REMOVE: begin
          if (in_range) begin
            cmd.op  = CELL_REMOVE;
            cmd.sel = MAX_IW'(in_ch.index);
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] nbr;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nbr = tail;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    pate_cell #(.CELL_ID(i)) u_cell (
      .clk    (clk),
      .cmd    (cmd),
      .nbr_i  (nbr),
      .load_i (in_ch.value),
      .q_o    (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_mode;
            idx_r   <= in_ch.index;
            key_r   <= in_ch.value;
            step_r  <= '0;
            found_r <= 1'b0;
            pos_r   <= '0;
            old_r   <= '0;
            case (in_mode)
              MODE_SEARCH: state_r <= S_WALK;
              MODE_MODIFY: begin
                if (in_range) begin
                  state_r <= S_WALK;
                end else begin
                  out_status_r   <= ST_RANGE;
                  out_position_r <= '0;
                  out_old_r      <= '0;
                  out_fill_r     <= FILL_W'(count_r);
                end
              end
              MODE_APPEND: begin
                out_position_r <= '0;
                out_old_r      <= '0;
                if (full) begin
                  out_status_r <= ST_FULL;
                  out_fill_r   <= FILL_W'(count_r);
                end else begin
                  count_r      <= count_inc;
                  out_status_r <= ST_OK;
                  out_fill_r   <= FILL_W'(count_inc);
                end
              end
              default: begin
                out_position_r <= '0;
                out_old_r      <= '0;
                if (in_range) begin
                  count_r      <= count_dec;
                  out_status_r <= ST_OK;
                  out_fill_r   <= FILL_W'(count_dec);
                end else begin
                  out_status_r <= ST_RANGE;
                  out_fill_r   <= FILL_W'(count_r);
                end
              end
            endcase
          end
        end
        S_WALK: begin
          step_r <= step_r + IW'(1);
          if (op_r == MODE_SEARCH && !found_r && (CW'(step_r) < count_r)
              && cell_q[0] == key_r) begin
            found_r <= 1'b1;
            pos_r   <= POSITION_W'(step_r);
          end
          if (op_r == MODE_MODIFY && hit_idx) old_r <= cell_q[0];
          if (step_r == LAST_STEP) state_r <= S_POST;
        end
        S_POST: begin
          if (out_free) begin
            out_status_r   <= (op_r == MODE_SEARCH && !found_r) ? ST_MISS : ST_OK;
            out_position_r <= pos_r;
            out_old_r      <= old_r;
            out_fill_r     <= FILL_W'(count_r);
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.position   = out_position_r;
  assign out_ch.old_value  = out_old_r;
  assign out_ch.fill_count = out_fill_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("fill count above table depth");

  a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && step_r != LAST_STEP) |=>
      (state_r == S_WALK && step_r == $past(step_r) + IW'(1)))
    else $error("rotation walk skipped a position");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_APPEND && !full) |=> count_r == $past(count_inc))
    else $error("append did not grow the table");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !accept)
    else $error("request beat taken during a walk");

endmodule

// ----- hdl/pate_cell.sv -----
// one cell, one entry: takes upper neighbor on rotate, on remove if id >= sel
module pate_cell #(
  parameter int CELL_ID = 0
) (
  input  logic                            clk,
  input  pate_pkg::cell_cmd_t             cmd,
  input  logic [pate_pkg::VALUE_W-1:0]    nbr_i,
  input  logic [pate_pkg::VALUE_W-1:0]    load_i,
  output logic [pate_pkg::VALUE_W-1:0]    q_o
);
  import pate_pkg::*;

  localparam logic [MAX_IW-1:0] MY_ID = MAX_IW'(CELL_ID);

  logic [VALUE_W-1:0] q_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_ROTATE: q_r <= nbr_i;
      CELL_REMOVE: begin
        if (MY_ID >= cmd.sel) q_r <= nbr_i;
      end
      CELL_APPEND: begin
        if (MY_ID == cmd.sel) q_r <= load_i;
      end
      default: ;
    endcase
  end

  assign q_o = q_r;

endmodule

// ----- verif/packed_array_table_engine_test.sv -----
// testbench for packed_array_table_engine: scripted rows vs listed results, random vs a shadow table
module packed_array_table_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pate_pkg::*;

  localparam int DEPTH          = 256;
  localparam int STALL_MAX      = 11;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SCRIPT_ROWS    = 25;
  localparam int STAGES         = 6;

  typedef struct packed {
    status_t                status;
    logic [POSITION_W-1:0]  position;
    logic signed [VALUE_W-1:0] old_value;
    logic [FILL_W-1:0]      fill_count;
  } table_result_t;

  typedef struct packed {
    mode_t                     mode;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    bit                        typed;
    table_result_t             want;
  } script_row_t;

  typedef enum int {
    GROW_STAGE,
    MIXED_STAGE,
    SHRINK_STAGE
  } stage_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  pate_in_if  in_ch ();
  pate_out_if out_ch ();

  packed_array_table_engine #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  logic signed [VALUE_W-1:0] shadow_entries [DEPTH];
  logic [FILL_W-1:0]         shadow_fill;
  table_result_t             pending_results [$];
  int                        failures;
  int                        quiet_cycles;
  bit                        in_idle;
  bit                        out_idle;

  script_row_t script [SCRIPT_ROWS] = '{
    '{MODE_SEARCH, 8'd0,   32'sd5,            1'b1, '{ST_MISS,  8'd0, 32'sd0,            9'd0}},
    '{MODE_MODIFY, 8'd0,   32'sd7,            1'b1, '{ST_RANGE, 8'd0, 32'sd0,            9'd0}},
    '{MODE_REMOVE, 8'd0,   32'sd0,            1'b1, '{ST_RANGE, 8'd0, 32'sd0,            9'd0}},
    '{MODE_APPEND, 8'd255, 32'sh7fffffff,     1'b1, '{ST_OK,    8'd0, 32'sd0,            9'd1}},
    '{MODE_APPEND, 8'd0,   32'sh80000000,     1'b1, '{ST_OK,    8'd0, 32'sd0,            9'd2}},
    '{MODE_APPEND, 8'd0,   -32'sd1,           1'b1, '{ST_OK,    8'd0, 32'sd0,            9'd3}},
    '{MODE_APPEND, 8'd0,   32'sd0,            1'b1, '{ST_OK,    8'd0, 32'sd0,            9'd4}},
    '{MODE_APPEND, 8'd0,   -32'sd1,           1'b1, '{ST_OK,    8'd0, 32'sd0,            9'd5}},
    '{MODE_SEARCH, 8'd0,   -32'sd1,           1'b1, '{ST_OK,    8'd2, 32'sd0,            9'd5}},
    '{MODE_SEARCH, 8'd0,   32'sh80000000,     1'b1, '{ST_OK,    8'd1, 32'sd0,            9'd5}},
    '{MODE_SEARCH, 8'd0,   32'sd0,            1'b1, '{ST_OK,    8'd3, 32'sd0,            9'd5}},
    '{MODE_SEARCH, 8'd0,   32'sh12345678,     1'b1, '{ST_MISS,  8'd0, 32'sd0,            9'd5}},
    '{MODE_MODIFY, 8'd1,   32'sh55555555,     1'b1, '{ST_OK,    8'd0, 32'sh80000000,     9'd5}},
    '{MODE_MODIFY, 8'd5,   32'sd0,            1'b1, '{ST_RANGE, 8'd0, 32'sd0,            9'd5}},
    '{MODE_MODIFY, 8'd255, 32'sd0,            1'b1, '{ST_RANGE, 8'd0, 32'sd0,            9'd5}},
    '{MODE_REMOVE, 8'd5,   32'sd0,            1'b1, '{ST_RANGE, 8'd0, 32'sd0,            9'd5}},
    '{MODE_REMOVE, 8'd255, 32'sd0,            1'b1, '{ST_RANGE, 8'd0, 32'sd0,            9'd5}},
    '{MODE_REMOVE, 8'd0,   32'sd0,            1'b1, '{ST_OK,    8'd0, 32'sd0,            9'd4}},
    '{MODE_SEARCH, 8'd0,   -32'sd1,           1'b1, '{ST_OK,    8'd1, 32'sd0,            9'd4}},
    '{MODE_REMOVE, 8'd3,   32'sd0,            1'b1, '{ST_OK,    8'd0, 32'sd0,            9'd3}},
    '{MODE_SEARCH, 8'd0,   32'sh7fffffff,     1'b1, '{ST_MISS,  8'd0, 32'sd0,            9'd3}},
    '{MODE_MODIFY, 8'd2,   32'shaaaaaaaa,     1'b1, '{ST_OK,    8'd0, 32'sd0,            9'd3}},
    '{MODE_REMOVE, 8'd1,   32'sd0,            1'b1, '{ST_OK,    8'd0, 32'sd0,            9'd2}},
    '{MODE_SEARCH, 8'd0,   32'shaaaaaaaa,     1'b1, '{ST_OK,    8'd1, 32'sd0,            9'd2}},
    '{MODE_MODIFY, 8'd0,   32'sh0f0f0f0f,     1'b0, '0}
  };

  stage_kind_t stage_plan [STAGES] = '{GROW_STAGE, MIXED_STAGE, SHRINK_STAGE,
                                       GROW_STAGE, MIXED_STAGE, SHRINK_STAGE};
  int          stage_len  [STAGES] = '{450, 250, 400, 450, 200, 200};

  function automatic table_result_t apply_request(input mode_t m,
                                                  input logic [INDEX_W-1:0] idx,
                                                  input logic signed [VALUE_W-1:0] v);
    table_result_t r;
    int            i;
    bit            found;
    r        = '0;
    r.status = ST_OK;
    found    = 1'b0;
    case (m)
      MODE_SEARCH: begin
        r.status = ST_MISS;
        for (i = 0; i < shadow_fill && !found; i++) begin
          if (shadow_entries[i] == v) begin
            found      = 1'b1;
            r.status   = ST_OK;
            r.position = i[POSITION_W-1:0];
          end
        end
      end
      MODE_MODIFY: begin
        if (idx >= shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          r.old_value         = shadow_entries[idx];
          shadow_entries[idx] = v;
        end
      end
      MODE_APPEND: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_fill[INDEX_W-1:0]] = v;
          shadow_fill                              = shadow_fill + 1'b1;
        end
      end
      default: begin
        if (idx >= shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(idx); i + 1 < shadow_fill; i++) begin
            shadow_entries[i] = shadow_entries[i+1];
          end
          shadow_fill = shadow_fill - 1'b1;
        end
      end
    endcase
    r.fill_count = shadow_fill;
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return $urandom;
    end else if (r < 6) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $signed($urandom_range(0, 7)) - 32'sd3;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 19);
    if (shadow_fill > 0 && r < 15) begin
      return INDEX_W'($urandom_range(0, int'(shadow_fill) - 1));
    end else if (r < 17) begin
      return (shadow_fill > 255) ? 8'd255 : shadow_fill[INDEX_W-1:0];
    end
    return INDEX_W'($urandom_range(0, 255));
  endfunction

  task automatic send_request(input mode_t m, input logic [INDEX_W-1:0] idx,
                              input logic signed [VALUE_W-1:0] v,
                              input bit typed, input table_result_t want);
    int            gap;
    table_result_t predicted;
    gap = in_idle ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= m;
    in_ch.index <= idx;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_request(m, idx, v);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic send_random(input stage_kind_t kind);
    int                        pick;
    mode_t                     m;
    logic signed [VALUE_W-1:0] v;
    pick = $urandom_range(0, 99);
    case (kind)
      GROW_STAGE:
        m = (pick < 75) ? MODE_APPEND : (pick < 85) ? MODE_SEARCH :
            (pick < 95) ? MODE_MODIFY : MODE_REMOVE;
      SHRINK_STAGE:
        m = (pick < 75) ? MODE_REMOVE : (pick < 85) ? MODE_SEARCH :
            (pick < 95) ? MODE_MODIFY : MODE_APPEND;
      default:
        m = (pick < 25) ? MODE_SEARCH : (pick < 50) ? MODE_MODIFY :
            (pick < 75) ? MODE_APPEND : MODE_REMOVE;
    endcase
    if (m == MODE_SEARCH && shadow_fill > 0 && $urandom_range(0, 99) < 60) begin
      v = shadow_entries[$urandom_range(0, int'(shadow_fill) - 1)];
    end else begin
      v = pick_value();
    end
    send_request(m, pick_index(), v, 1'b0, '0);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      failures++;
    end
  endtask

  // result side: random stalls, every accepted beat checked against the oldest expectation
  initial begin
    int            gap;
    table_result_t want;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = out_idle ? $urandom_range(0, STALL_MAX) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, status %0h fill %0h",
                 $time, out_ch.status, out_ch.fill_count);
        failures++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, out_ch.status);
        compare_field("position", want.position, out_ch.position);
        compare_field("old_value", want.old_value, out_ch.old_value);
        compare_field("fill_count", want.fill_count, out_ch.fill_count);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("packed_array_table_engine verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int k;
    int s;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_SEARCH;
    in_ch.index  = '0;
    in_ch.value  = '0;
    shadow_fill  = '0;
    failures     = 0;
    quiet_cycles = 0;
    in_idle      = 1'b1;
    out_idle     = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < SCRIPT_ROWS; k++) begin
      send_request(script[k].mode, script[k].index, script[k].value,
                   script[k].typed, script[k].want);
    end

    for (s = 0; s < STAGES; s++) begin
      in_idle  = $urandom_range(0, 3) != 0;
      out_idle = $urandom_range(0, 3) != 0;
      repeat (stage_len[s]) send_random(stage_plan[s]);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (failures == 0) begin
      $display("packed_array_table_engine verification clean");
    end else begin
      $display("packed_array_table_engine verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pate_pkg.sv
hdl/pate_ifs.sv
hdl/pate_cell.sv
hdl/packed_array_table_engine.sv
verif/packed_array_table_engine_test.sv
